/* hdl/dbps_pkg.sv */
// Shared types and constants for the DC bus precharge sequencer.
`default_nettype none

package dbps_pkg;

	// Sequence phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_CHARGE,
		PH_TEST
	} phase_t;

	// Tick command codes
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_CONNECT    = 2'd1;
	localparam logic [1:0] OP_DISCONNECT = 2'd2;

	// Reported status codes
	localparam logic [1:0] ST_DISCONNECTED = 2'd0;
	localparam logic [1:0] ST_RUNNING      = 2'd1;
	localparam logic [1:0] ST_CONNECTED    = 2'd2;
	localparam logic [1:0] ST_FAILED       = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_MIN_VOLTAGE     = 3'd0;
	localparam logic [2:0] CFG_MAX_RISE        = 3'd1;
	localparam logic [2:0] CFG_LOAD_DROP_LIMIT = 3'd2;
	localparam logic [2:0] CFG_RELAY_SETTLE    = 3'd3;
	localparam logic [2:0] CFG_SAMPLE_PERIOD   = 3'd4;
	localparam logic [2:0] CFG_CHARGE_TIMEOUT  = 3'd5;
	localparam logic [2:0] CFG_HEATER_TEST     = 3'd6;

	localparam int VOLT_W = 14;
	localparam int TICK_W = 16;
	localparam int SAMP_W = 10;

	// Configuration register file contents
	typedef struct packed {
		logic [VOLT_W-1:0] min_voltage;
		logic [VOLT_W-1:0] max_rise;
		logic [VOLT_W-1:0] load_drop_limit;
		logic [TICK_W-1:0] relay_settle_ticks;
		logic [TICK_W-1:0] sample_period_ticks;
		logic [SAMP_W-1:0] charge_timeout_samples;
		logic [TICK_W-1:0] heater_test_ticks;
	} cfg_t;

	// Relay drive, bus relay in the lowest bit
	typedef struct packed {
		logic heater;
		logic inverter;
		logic bypass;
		logic bus;
	} relay_t;

endpackage

`default_nettype wire

/* hdl/dbps_seq.sv */
// Precharge sequence state machine, advanced once per tick.
`default_nettype none

module dbps_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [1:0]                  op,
	input  wire logic [dbps_pkg::VOLT_W-1:0] bus_voltage,
	input  wire dbps_pkg::cfg_t              cfg,
	output dbps_pkg::relay_t                 relays,
	output logic [1:0]                       status
);
	import dbps_pkg::*;

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [SAMP_W-1:0] samples_q, samples_d;
	logic [VOLT_W-1:0] prev_q, prev_d;
	logic [VOLT_W-1:0] start_q, start_d;
	relay_t            relays_q, relays_d;
	logic [1:0]        status_q, status_d;

	logic [TICK_W-1:0] tick_inc;
	logic              low;
	logic              rising;
	logic              dropped;
	logic              wait_done;
	logic [SAMP_W-1:0] samples_eval;

	// Compare against thresholds; sums are one bit wider so nothing wraps
	assign tick_inc = tick_q + TICK_W'(1);
	assign low      = bus_voltage < cfg.min_voltage;
	assign rising   = {1'b0, bus_voltage} > ({1'b0, prev_q} + {1'b0, cfg.max_rise});
	assign dropped  = {1'b0, start_q} > ({1'b0, bus_voltage} + {1'b0, cfg.load_drop_limit});

	// Hold state between steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			samples_q <= '0;
			prev_q    <= '0;
			start_q   <= '0;
			relays_q  <= '0;
			status_q  <= ST_DISCONNECTED;
		end else if (step) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			samples_q <= samples_d;
			prev_q    <= prev_d;
			start_q   <= start_d;
			relays_q  <= relays_d;
			status_q  <= status_d;
		end
	end

	// Next state for one tick
	always_comb begin
		phase_d      = phase_q;
		tick_d       = tick_q;
		samples_d    = samples_q;
		prev_d       = prev_q;
		start_d      = start_q;
		relays_d     = relays_q;
		status_d     = status_q;
		wait_done    = 1'b0;
		samples_eval = samples_q;

		case (phase_q)
			PH_IDLE: begin
				if (op == OP_CONNECT) begin
					relays_d          = '0;
					relays_d.inverter = 1'b1;
					relays_d.bus      = 1'b1;
					status_d          = ST_RUNNING;
					phase_d           = PH_SETTLE;
					tick_d            = '0;
					samples_d         = cfg.charge_timeout_samples;
					prev_d            = '0;
				end else if (op == OP_DISCONNECT) begin
					relays_d = '0;
					status_d = ST_DISCONNECTED;
				end
			end
			PH_SETTLE: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.relay_settle_ticks) begin
					wait_done = 1'b1;
				end
			end
			PH_CHARGE: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.sample_period_ticks) begin
					wait_done = 1'b1;
					prev_d    = bus_voltage;
					if (samples_q != '0) begin
						samples_eval = samples_q - SAMP_W'(1);
					end
					samples_d = samples_eval;
				end
			end
			PH_TEST: begin
				tick_d = tick_inc;
				if (tick_inc >= cfg.heater_test_ticks) begin
					tick_d  = '0;
					phase_d = PH_IDLE;
					if (samples_q == '0 || dropped) begin
						relays_d = '0;
						status_d = ST_FAILED;
					end else begin
						relays_d.heater = 1'b0;
						relays_d.bypass = 1'b1;
						status_d        = ST_CONNECTED;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// Keep sampling or move on to the heater load test
		if (wait_done) begin
			tick_d = '0;
			if ((low || rising) && samples_eval != '0) begin
				phase_d = PH_CHARGE;
			end else begin
				start_d         = bus_voltage;
				relays_d.heater = 1'b1;
				phase_d         = PH_TEST;
			end
		end
	end

	assign relays = relays_q;
	assign status = status_q;

endmodule

`default_nettype wire

/* hdl/dc_bus_precharge_sequencer_core.sv */
// Top level of the DC bus precharge sequencer: stream ports, config registers.
//
//   channel  dir  width      contents
//   s_axis   in   16 + 2     tick: bus voltage sample, command in tuser
//   m_axis   out  8          relay drive and status after the tick
//   cfg      in   3 + 16     register write, no read-back
//
// One tick per clock while the output is not stalled; a tick passes through the input
// register and then the state/result register before its result appears.
// Reset clears the sequence to idle with all relays open and the config
// registers to their defaults. An output stall holds the state and the
// input register; one more input transfer is taken while a result waits.
`default_nettype none

module dc_bus_precharge_sequencer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [13:0] bus_voltage, [15:14] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] op
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [0] bus_relay_on, [1] bypass_relay_on,
	                                    // [2] inverter_relay_on, [3] heater_on,
	                                    // [5:4] status, [7:6] zero
	// Configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import dbps_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [VOLT_W-1:0] volt_s1;
	logic              out_valid_q;
	logic              advance;
	relay_t            relays;
	logic [1:0]        status;

	// Step the sequence when a tick is held and the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_voltage            <= VOLT_W'(1600);
			cfg_q.max_rise               <= VOLT_W'(32);
			cfg_q.load_drop_limit        <= VOLT_W'(160);
			cfg_q.relay_settle_ticks     <= TICK_W'(80);
			cfg_q.sample_period_ticks    <= TICK_W'(100);
			cfg_q.charge_timeout_samples <= SAMP_W'(600);
			cfg_q.heater_test_ticks      <= TICK_W'(2000);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_VOLTAGE:     cfg_q.min_voltage            <= cfg_wdata[VOLT_W-1:0];
				CFG_MAX_RISE:        cfg_q.max_rise               <= cfg_wdata[VOLT_W-1:0];
				CFG_LOAD_DROP_LIMIT: cfg_q.load_drop_limit        <= cfg_wdata[VOLT_W-1:0];
				CFG_RELAY_SETTLE:    cfg_q.relay_settle_ticks     <= cfg_wdata;
				CFG_SAMPLE_PERIOD:   cfg_q.sample_period_ticks    <= cfg_wdata;
				CFG_CHARGE_TIMEOUT:  cfg_q.charge_timeout_samples <= cfg_wdata[SAMP_W-1:0];
				CFG_HEATER_TEST:     cfg_q.heater_test_ticks      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Track input register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the tick on transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			volt_s1 <= s_tdata[VOLT_W-1:0];
		end
	end

	dbps_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op          (op_s1),
		.bus_voltage (volt_s1),
		.cfg         (cfg_q),
		.relays      (relays),
		.status      (status)
	);

	// Sequence registers double as the result register
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, status, relays};

endmodule

`default_nettype wire

/* hdl/dbps_checker.sv */
// Port-level checks for the precharge sequencer and their bind.
`default_nettype none

module dbps_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata
);
	import dbps_pkg::*;

	// Heater load only with inverter and bus relays closed
	a_heater_needs_relays: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[2])
		else $error("heater on without bus and inverter relays");

	// Bypass closes only once connected
	a_bypass_connected: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[5:4] == ST_CONNECTED)
		else $error("bypass relay closed while not connected");

	// Disconnected or failed means every relay open
	a_open_when_down: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:4] == ST_DISCONNECTED || m_tdata[5:4] == ST_FAILED)
		|-> m_tdata[3:0] == 4'b0000)
		else $error("relay closed while disconnected or failed");

	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind dc_bus_precharge_sequencer_core dbps_checker u_dbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
